### src/olist_pkg.sv
// shared types, widths and codes for the ordered list unit
package olist_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int CNT_W        = 8;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int CAPACITY_DEF = 128;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR  = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_SEARCH = 3'd3,
        K_READ   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch the accepted word
        logic start;     // run checks, init pointer
        logic rd;        // issue a list read
        logic wb;        // use read data: shift write or compare
        logic fin;       // closing write and count update
        logic out_load;  // move result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic no_loop;   // operation finished after checks
        logic more;      // another element to visit
        logic stop;      // read data ends the operation
    } sts_t;

endpackage

### src/ordered_list_insert_delete_search_unit.sv
// top level of the ordered list unit: stream ports, sequencer and datapath
//
// keeps an ordered list of up to CAPACITY signed 32-bit values in a one-write,
// one-read memory with a registered read, plus an entry count. each input word
// carries one operation (clear, insert, delete, search, read) and yields
// exactly one result word. one operation is in flight at a time; its length
// is set by the element loop, which visits list entries one at a time, each
// with a memory read, then a write-back or compare:
//   clear, unused kind or any failed check: no loop
//   insert at position p with n entries: n-p+1 entries shifted
//   delete at position p with n entries: n-p entries shifted
//   search hitting position k: k entries visited, a miss all n
//   read: one entry
// a finished result sits in the output register while the next word is taken;
// the last step waits as long as an earlier result is still unread.
// status codes: 0 ok, 1 full, 2 empty, 3 bad position, 4 not found.
module ordered_list_insert_delete_search_unit #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
    input  logic [2:0]  s_tuser,   // [2:0] kind
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] found_position, [39:8] read_value, [47:40] count
    output logic [2:0]  m_tuser    // [2:0] status
);

    olist_pkg::cmd_t cmd;
    olist_pkg::sts_t sts;

    logic [olist_pkg::STATUS_W-1:0]      out_status;
    logic [olist_pkg::POS_W-1:0]         out_found_position;
    logic signed [olist_pkg::DATA_W-1:0] out_read_value;
    logic [olist_pkg::CNT_W-1:0]         out_count;

    // sequencer: handshakes and step commands
    olist_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: list memory, count, pointer, result registers
    olist_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .in_kind            (s_tuser),
        .in_position        (s_tdata[7:0]),
        .in_value           (s_tdata[39:8]),
        .out_status         (out_status),
        .out_found_position (out_found_position),
        .out_read_value     (out_read_value),
        .out_count          (out_count)
    );

    // pack result word
    assign m_tdata = {out_count, out_read_value, out_found_position};
    assign m_tuser = out_status;

    // an accepted word blocks further input until its result is loaded into the output register
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an operation is in flight");

    // reported count never exceeds the list capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:40] <= olist_pkg::CNT_W'(CAPACITY)))
        else $error("count above capacity");

    // a nonzero position only comes with an ok status
    a_pos_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[7:0] != 8'd0) |-> (m_tuser == olist_pkg::ST_OK))
        else $error("position reported on a failed operation");

    // failed operations report a zero value
    a_val_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != olist_pkg::ST_OK) |-> (m_tdata[39:8] == 32'd0))
        else $error("value reported on a failed operation");

endmodule

### src/olist_ctrl.sv
// sequencer for the ordered list unit
module olist_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  olist_pkg::sts_t    sts,
    output olist_pkg::cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_LOOP  = 6'b000100,
        S_WB    = 6'b001000,
        S_FIN   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START: begin
                cmd.start  = 1'b1;
                state_next = sts.no_loop ? S_DONE : S_LOOP;
            end
            S_LOOP: begin
                if (sts.more) begin
                    cmd.rd     = 1'b1;
                    state_next = S_WB;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_WB: begin
                cmd.wb     = 1'b1;
                state_next = sts.stop ? S_FIN : S_LOOP;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### src/olist_dp.sv
// list memory, pointer, count and result registers
module olist_dp #(
    parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  olist_pkg::cmd_t                      cmd,
    output olist_pkg::sts_t                      sts,
    input  logic [olist_pkg::KIND_W-1:0]         in_kind,
    input  logic [olist_pkg::POS_W-1:0]          in_position,
    input  logic signed [olist_pkg::DATA_W-1:0]  in_value,
    output logic [olist_pkg::STATUS_W-1:0]       out_status,
    output logic [olist_pkg::POS_W-1:0]          out_found_position,
    output logic signed [olist_pkg::DATA_W-1:0]  out_read_value,
    output logic [olist_pkg::CNT_W-1:0]          out_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [olist_pkg::CNT_W-1:0] CAP_C = olist_pkg::CNT_W'(CAPACITY);

    logic [olist_pkg::DATA_W-1:0] mem [CAPACITY];

    logic [olist_pkg::KIND_W-1:0]   kind_reg;
    logic [olist_pkg::POS_W-1:0]    pos_reg;
    logic [olist_pkg::DATA_W-1:0]   value_reg;
    logic [olist_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [olist_pkg::CNT_W-1:0]    ptr_reg, ptr_next;
    logic [olist_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [olist_pkg::POS_W-1:0]    fpos_reg, fpos_next;
    logic [olist_pkg::DATA_W-1:0]   rval_reg, rval_next;
    logic [olist_pkg::DATA_W-1:0]   rdata_reg;

    logic [olist_pkg::POS_W-1:0]    pos_m1;
    logic [olist_pkg::CNT_W:0]      cnt_p1;
    logic [olist_pkg::CNT_W:0]      ptr_p1;
    logic                           ins_pos_ok, pos_ok, hit;
    logic [olist_pkg::STATUS_W-1:0] chk;
    logic [olist_pkg::CNT_W-1:0]    raddr_w;
    logic [olist_pkg::CNT_W-1:0]    waddr_w;
    logic                           we;
    logic [olist_pkg::DATA_W-1:0]   wdata;

    assign pos_m1     = pos_reg - 8'd1;
    assign cnt_p1     = {1'b0, count_reg} + 9'd1;
    assign ptr_p1     = {1'b0, ptr_reg} + 9'd1;
    assign ins_pos_ok = (pos_reg != '0) && ({1'b0, pos_reg} <= cnt_p1);
    assign pos_ok     = (pos_reg != '0) && (pos_reg <= count_reg);
    assign hit        = (rdata_reg == value_reg);

    // checks, loop condition and read address per operation
    always_comb begin
        chk         = olist_pkg::ST_BADPOS;
        sts.no_loop = 1'b1;
        sts.more    = 1'b0;
        sts.stop    = 1'b0;
        raddr_w     = ptr_reg;
        case (kind_reg)
            olist_pkg::K_CLEAR: begin
                chk = olist_pkg::ST_OK;
            end
            olist_pkg::K_INSERT: begin
                if (count_reg >= CAP_C) begin
                    chk = olist_pkg::ST_FULL;
                end else if (ins_pos_ok) begin
                    chk = olist_pkg::ST_OK;
                end
                sts.no_loop = (chk != olist_pkg::ST_OK);
                sts.more    = (ptr_reg >= pos_reg);
                raddr_w     = ptr_reg - 8'd1;
            end
            olist_pkg::K_DELETE, olist_pkg::K_READ: begin
                if (count_reg == '0) begin
                    chk = olist_pkg::ST_EMPTY;
                end else if (pos_ok) begin
                    chk = olist_pkg::ST_OK;
                end
                sts.no_loop = (chk != olist_pkg::ST_OK);
                if (kind_reg == olist_pkg::K_DELETE) begin
                    sts.more = (ptr_p1 < {1'b0, count_reg});
                    raddr_w  = ptr_p1[olist_pkg::CNT_W-1:0];
                end else begin
                    sts.more = 1'b1;
                    sts.stop = 1'b1;
                end
            end
            olist_pkg::K_SEARCH: begin
                chk         = olist_pkg::ST_NOTFOUND;
                sts.no_loop = 1'b0;
                sts.more    = (ptr_reg < count_reg);
                sts.stop    = hit;
            end
            default: ;
        endcase
    end

    // memory write: shift step or final insert
    always_comb begin
        we      = 1'b0;
        waddr_w = ptr_reg;
        wdata   = rdata_reg;
        if (cmd.wb && (kind_reg == olist_pkg::K_INSERT || kind_reg == olist_pkg::K_DELETE)) begin
            we = 1'b1;
        end else if (cmd.fin && kind_reg == olist_pkg::K_INSERT) begin
            we      = 1'b1;
            waddr_w = pos_m1;
            wdata   = value_reg;
        end
    end

    always_comb begin
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        fpos_next   = fpos_reg;
        rval_next   = rval_reg;
        if (cmd.start) begin
            status_next = chk;
            fpos_next   = '0;
            rval_next   = '0;
            case (kind_reg)
                olist_pkg::K_CLEAR:  count_next = '0;
                olist_pkg::K_INSERT: ptr_next   = count_reg;
                olist_pkg::K_SEARCH: ptr_next   = '0;
                default:             ptr_next   = pos_m1;
            endcase
        end else if (cmd.wb) begin
            case (kind_reg)
                olist_pkg::K_INSERT: ptr_next = ptr_reg - 8'd1;
                olist_pkg::K_DELETE: ptr_next = ptr_p1[olist_pkg::CNT_W-1:0];
                olist_pkg::K_SEARCH: begin
                    if (hit) begin
                        status_next = olist_pkg::ST_OK;
                        fpos_next   = ptr_p1[olist_pkg::POS_W-1:0];
                    end else begin
                        ptr_next = ptr_p1[olist_pkg::CNT_W-1:0];
                    end
                end
                olist_pkg::K_READ: begin
                    rval_next = rdata_reg;
                    fpos_next = pos_reg;
                end
                default: ;
            endcase
        end else if (cmd.fin) begin
            case (kind_reg)
                olist_pkg::K_INSERT: count_next = cnt_p1[olist_pkg::CNT_W-1:0];
                olist_pkg::K_DELETE: count_next = count_reg - 8'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr_w[AW-1:0]] <= wdata;
        end
        if (cmd.rd) begin
            rdata_reg <= mem[raddr_w[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= in_kind;
            pos_reg   <= in_position;
            value_reg <= in_value;
        end
        ptr_reg    <= ptr_next;
        status_reg <= status_next;
        fpos_reg   <= fpos_next;
        rval_reg   <= rval_next;
        if (cmd.out_load) begin
            out_status         <= status_reg;
            out_found_position <= fpos_reg;
            out_read_value     <= rval_reg;
            out_count          <= count_reg;
        end
    end

endmodule

### test/testbench.sv
// self-checking testbench for the ordered list unit: directed table, then random list sessions
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import olist_pkg::*;

    localparam int CAPACITY      = CAPACITY_DEF;
    localparam int RANDOM_WORDS  = 1900;
    localparam int DIRECTED_ROWS = 26;
    localparam int PRESSURE_AT   = 300;   // input words accepted before the long hold-off
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;   // longer than the slowest operation
    localparam int MAX_REPORTS   = 10;

    // kind codes the block does not define; they must come back as bad position
    localparam logic [KIND_W-1:0] K_UNUSED5 = 3'd5;
    localparam logic [KIND_W-1:0] K_UNUSED7 = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    fpos;
        logic [DATA_W-1:0]   rval;
        logic [CNT_W-1:0]    count;
    } list_result_t;

    localparam list_result_t NO_RESULT = '0;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
        bit                typed;   // use res as written instead of the predictor
        list_result_t      res;
    } stim_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;    // [7:0] position, [39:8] value
    logic [2:0]  s_tuser  = '0;    // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;          // [7:0] found_position, [39:8] read_value, [47:40] count
    logic [2:0]  m_tuser;          // [2:0] status

    // predictor state: list contents and entry count
    logic [DATA_W-1:0] model_list [CAPACITY];
    int                model_count = 0;

    list_result_t pending_results [$];
    int           words_in    = 0;
    int           error_count = 0;
    logic         hold_off    = 1'b0;

    // directed words: empty-list errors, extremes, bad positions, unused kinds, clear
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{K_READ,    8'd1,   32'd0,         1'b1, {ST_EMPTY,    8'd0, 32'd0, 8'd0}},
        '{K_DELETE,  8'd1,   32'd0,         1'b1, {ST_EMPTY,    8'd0, 32'd0, 8'd0}},
        '{K_SEARCH,  8'd0,   32'd0,         1'b1, {ST_NOTFOUND, 8'd0, 32'd0, 8'd0}},
        '{K_INSERT,  8'd0,   32'd5,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd0}},
        '{K_INSERT,  8'd2,   32'd5,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd0}},
        '{K_INSERT,  8'd1,   32'h7fff_ffff, 1'b1, {ST_OK,       8'd0, 32'd0, 8'd1}},
        '{K_INSERT,  8'd1,   32'h8000_0000, 1'b1, {ST_OK,       8'd0, 32'd0, 8'd2}},
        '{K_INSERT,  8'd3,   32'hffff_ffff, 1'b1, {ST_OK,       8'd0, 32'd0, 8'd3}},
        '{K_READ,    8'd1,   32'd0,         1'b1, {ST_OK, 8'd1, 32'h8000_0000, 8'd3}},
        '{K_READ,    8'd3,   32'd0,         1'b1, {ST_OK, 8'd3, 32'hffff_ffff, 8'd3}},
        '{K_READ,    8'd4,   32'd0,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd3}},
        '{K_READ,    8'd0,   32'd0,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd3}},
        '{K_READ,    8'd255, 32'hffff_ffff, 1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd3}},
        '{K_SEARCH,  8'd0,   32'h7fff_ffff, 1'b1, {ST_OK,       8'd2, 32'd0, 8'd3}},
        '{K_SEARCH,  8'd0,   32'd0,         1'b1, {ST_NOTFOUND, 8'd0, 32'd0, 8'd3}},
        '{K_INSERT,  8'd2,   32'd0,         1'b0, NO_RESULT},
        '{K_INSERT,  8'd5,   32'd0,         1'b0, NO_RESULT},
        '{K_SEARCH,  8'd0,   32'd0,         1'b0, NO_RESULT},   // duplicate: first hit wins
        '{K_DELETE,  8'd0,   32'd0,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd5}},
        '{K_DELETE,  8'd6,   32'd0,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd5}},
        '{K_DELETE,  8'd5,   32'd0,         1'b0, NO_RESULT},
        '{K_DELETE,  8'd1,   32'd0,         1'b0, NO_RESULT},
        '{K_UNUSED5, 8'd1,   32'd0,         1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd3}},
        '{K_UNUSED7, 8'd255, 32'hffff_ffff, 1'b1, {ST_BADPOS,   8'd0, 32'd0, 8'd3}},
        '{K_CLEAR,   8'd0,   32'd0,         1'b1, {ST_OK,       8'd0, 32'd0, 8'd0}},
        '{K_READ,    8'd0,   32'd0,         1'b1, {ST_EMPTY,    8'd0, 32'd0, 8'd0}}
    };

    ordered_list_insert_delete_search_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    // applies one operation to the predicted list and returns its result word
    function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [DATA_W-1:0] val);
        list_result_t r;
        int p;
        r = '0;
        r.status = ST_OK;
        p = pos;
        case (kind)
            K_CLEAR: begin
                model_count = 0;
            end
            K_INSERT: begin
                // fullness wins over a bad position
                if (model_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > model_count + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = model_count; i >= p; i--)
                        model_list[i] = model_list[i - 1];
                    model_list[p - 1] = val;
                    model_count++;
                end
            end
            K_DELETE: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > model_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int i = p - 1; i + 1 < model_count; i++)
                        model_list[i] = model_list[i + 1];
                    model_count--;
                end
            end
            K_SEARCH: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < model_count; i++) begin
                    if (model_list[i] == val) begin
                        r.status = ST_OK;
                        r.fpos = POS_W'(i + 1);
                        break;
                    end
                end
            end
            K_READ: begin
                if (model_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > model_count) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.fpos = pos;
                    r.rval = model_list[p - 1];
                end
            end
            default: begin
                r.status = ST_BADPOS;
            end
        endcase
        r.count = CNT_W'(model_count);
        return r;
    endfunction

    // extremes, a small pool for duplicates, and full-range values
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            4, 5, 6: return DATA_W'($urandom_range(7));
            default: return $urandom;
        endcase
    endfunction

    // idling phases by words accepted: none, sender, receiver, both lightly
    function automatic int sender_idle_pct();
        if (words_in >= 500 && words_in < 1000) return 83;
        if (words_in >= 1500) return 15;
        return 0;
    endfunction

    function automatic int receiver_stall_pct();
        if (words_in >= 1000 && words_in < 1500) return 83;
        if (words_in >= 1500) return 15;
        return 0;
    endfunction

    // offers one word until taken, then records what it must produce
    task automatic send_word(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                             input logic [DATA_W-1:0] val, input bit typed = 1'b0,
                             input list_result_t typed_res = '0);
        list_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {val, pos};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_list_op(kind, pos, val);
        pending_results.push_back(typed ? typed_res : predicted);
        words_in++;
    endtask

    task automatic report_mismatch(input string what, input list_result_t want,
                                   input list_result_t got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t %s: status %0d/%0d pos %0d/%0d value %h/%h count %0d/%0d (exp/act)",
                     $realtime, what, want.status, got.status, want.fpos, got.fpos,
                     want.rval, got.rval, want.count, got.count);
    endtask

    // result side: random stalls, plus the long hold-off
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct());
    end

    // compare each result word with the oldest expectation
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[7:0], m_tdata[39:8], m_tdata[47:40]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", NO_RESULT, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.fpos !== want.fpos ||
                    got.rval !== want.rval || got.count !== want.count)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    // hold the result side off long enough for the input to back up
    initial begin
        wait (words_in >= PRESSURE_AT);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int target;
        int ops;
        int r;
        int guard;
        logic [KIND_W-1:0] k;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[n])
            send_word(directed_rows[n].kind, directed_rows[n].pos, directed_rows[n].val,
                      directed_rows[n].typed, directed_rows[n].res);

        // random sessions: clear, grow to a target size, then mixed operations;
        // mostly small lists, now and then a full one
        while (words_in < DIRECTED_ROWS + RANDOM_WORDS) begin
            target = ($urandom_range(7) == 0) ? CAPACITY : $urandom_range(12);
            send_word(K_CLEAR, POS_W'($urandom_range(255)), $urandom);
            while (model_count < target)
                send_word(K_INSERT, ($urandom_range(1) != 0) ? POS_W'(model_count + 1)
                                    : POS_W'($urandom_range(model_count + 1, 1)), pick_value());
            ops = $urandom_range(40, 10);
            repeat (ops) begin
                r   = $urandom_range(99);
                val = pick_value();
                pos = (model_count == 0) ? POS_W'($urandom_range(2))
                                         : POS_W'($urandom_range(model_count, 1));
                if (r < 3) begin
                    k = KIND_W'($urandom_range(K_UNUSED7, K_UNUSED5));
                end else if (r < 4) begin
                    k = K_CLEAR;
                end else if (r < 30) begin
                    k = K_INSERT;
                    if ($urandom_range(3) == 0)
                        pos = POS_W'(model_count + 1);
                    // keep small sessions from drifting upward
                    if (target < CAPACITY && model_count > target + 6)
                        k = K_DELETE;
                end else if (r < 52) begin
                    k = K_DELETE;
                end else if (r < 76) begin
                    k = K_SEARCH;
                    if (model_count > 0 && $urandom_range(3) != 0)
                        val = model_list[$urandom_range(model_count - 1)];
                end else begin
                    k = K_READ;
                end
                if ($urandom_range(15) == 0)
                    pos = POS_W'($urandom_range(255));
                send_word(k, pos, val);
            end
        end
        s_tvalid <= 1'b0;

        for (guard = 0; guard < 100000 && pending_results.size() != 0; guard++)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_results.size() != 0) begin
            $display("%0d result words never arrived", pending_results.size());
            error_count += pending_results.size();
        end

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // safety net well beyond the slowest legal run
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### ordered_list_insert_delete_search_unit.f
src/olist_pkg.sv
src/olist_ctrl.sv
src/olist_dp.sv
src/ordered_list_insert_delete_search_unit.sv
test/testbench.sv
